/* design/swk_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding window k-th smallest: shared definitions
// Control bundle for the cell chain and configuration register indexes.
// ----------------------------------------------------------------------------
package swk_pkg;

	typedef struct packed {
		logic shift;
		logic load;
		logic count;
		logic collect;
	} swk_ctl_t;

	localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [1:0] REG_RANK       = 2'd1;

endpackage

/* design/swk_cell.sv */
// ----------------------------------------------------------------------------
// Sliding window k-th smallest: ranking cell
// Holds one window sample and counts how many window samples lie below it
// and up to it as a probe value circulates past it; then offers its sample
// to the result chain if its order position covers the requested rank.
// ----------------------------------------------------------------------------
module swk_cell
	import swk_pkg::*;
#(
	parameter int VB = 16,
	parameter int CW = 7,
	parameter int WW = 7
) (
	input  logic          clk,
	input  swk_ctl_t      ctl,
	input  logic          in_win,
	input  logic [WW-1:0] k,
	input  logic [VB-1:0] sample_in,
	output logic [VB-1:0] sample_out,
	input  logic [VB-1:0] probe_in,
	input  logic          probe_win_in,
	output logic [VB-1:0] probe_out,
	output logic          probe_win_out,
	input  logic [VB-1:0] res_in,
	output logic [VB-1:0] res_out
);

	logic [VB-1:0] sample_q;
	logic [VB-1:0] probe_q;
	logic          probe_win_q;
	logic [CW-1:0] below_q;
	logic [CW-1:0] upto_q;
	logic [VB-1:0] res_q;
	logic          match;

	assign match = in_win && (WW'(below_q) < k) && (k <= WW'(upto_q));

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			sample_q <= sample_in;
		end
		if (ctl.load) begin
			probe_q     <= sample_q;
			probe_win_q <= in_win;
			below_q     <= '0;
			upto_q      <= '0;
		end else if (ctl.count) begin
			probe_q     <= probe_in;
			probe_win_q <= probe_win_in;
			if (probe_win_q && (probe_q < sample_q)) begin
				below_q <= below_q + CW'(1);
			end
			if (probe_win_q && (probe_q <= sample_q)) begin
				upto_q <= upto_q + CW'(1);
			end
		end
		if (ctl.collect) begin
			res_q <= match ? sample_q : res_in;
		end
	end

	assign sample_out    = sample_q;
	assign probe_out     = probe_q;
	assign probe_win_out = probe_win_q;
	assign res_out       = res_q;

endmodule

/* design/sliding_window_kth_smallest.sv */
// ----------------------------------------------------------------------------
// Sliding window k-th smallest
// Rank-order filter over the most recent samples of a stream.
// ----------------------------------------------------------------------------
// Samples shift into a chain of MAX_WINDOW cells, newest first. Once the
// window holds window_len samples, each transfer yields one result: the
// rank-th smallest sample of the window (zero when rank is zero or exceeds
// the window). A sample that produces no result leaves the block ready
// for the next; one that does holds off the next sample while the probe
// ring carries every window sample past every cell and the result chain
// walks the cells towards the output register. A waiting result does not
// block the ring work of the next sample.
module sliding_window_kth_smallest
	import swk_pkg::*;
#(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sample_value
	input  logic        s_tuser,   // restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // kth_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam int VB = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int WW = (CW > 7) ? CW : 7;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_LOAD    = 4'b0010,
		ST_COUNT   = 4'b0100,
		ST_COLLECT = 4'b1000
	} swk_state_t;

	swk_state_t    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] fill_next;
	logic [6:0]    window_len_q;
	logic [6:0]    rank_q;
	logic          m_tvalid_q;
	logic [15:0]   m_tdata_q;
	logic [WW-1:0] wl_ext;
	logic [CW-1:0] wl_eff;
	logic [WW-1:0] k_ext;
	logic          in_xfer;
	logic          out_free;
	swk_ctl_t      ctl;

	logic [VB-1:0] samp_w [MAX_WINDOW];
	logic [VB-1:0] probe_w [MAX_WINDOW];
	logic          pwin_w [MAX_WINDOW];
	logic [VB-1:0] res_w [MAX_WINDOW];

	assign wl_ext = WW'(window_len_q);
	always_comb begin
		if (wl_ext == '0) begin
			wl_eff = CW'(1);
		end else if (wl_ext > WW'(MAX_WINDOW)) begin
			wl_eff = CW'(MAX_WINDOW);
		end else begin
			wl_eff = CW'(wl_ext);
		end
	end
	assign k_ext = WW'(rank_q);

	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_comb begin
		if (s_tuser) begin
			fill_next = CW'(1);
		end else if (fill_q == CW'(MAX_WINDOW)) begin
			fill_next = fill_q;
		end else begin
			fill_next = fill_q + CW'(1);
		end
	end

	always_comb begin
		ctl.shift   = in_xfer;
		ctl.load    = (state_q == ST_LOAD);
		ctl.count   = (state_q == ST_COUNT);
		ctl.collect = (state_q == ST_COLLECT);
	end

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic [VB-1:0] sample_in;
		logic [VB-1:0] probe_in;
		logic          probe_win_in;
		logic [VB-1:0] res_in;
		logic          in_win;

		if (i == 0) begin : g_head
			assign sample_in    = s_tdata[VB-1:0];
			assign probe_in     = probe_w[MAX_WINDOW-1];
			assign probe_win_in = pwin_w[MAX_WINDOW-1];
			assign res_in       = '0;
		end else begin : g_body
			assign sample_in    = samp_w[i-1];
			assign probe_in     = probe_w[i-1];
			assign probe_win_in = pwin_w[i-1];
			assign res_in       = res_w[i-1];
		end

		assign in_win = (CW'(i) < wl_eff);

		swk_cell #(
			.VB(VB),
			.CW(CW),
			.WW(WW)
		) u_cell (
			.clk          (clk),
			.ctl          (ctl),
			.in_win       (in_win),
			.k            (k_ext),
			.sample_in    (sample_in),
			.sample_out   (samp_w[i]),
			.probe_in     (probe_in),
			.probe_win_in (probe_win_in),
			.probe_out    (probe_w[i]),
			.probe_win_out(pwin_w[i]),
			.res_in       (res_in),
			.res_out      (res_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= 7'd3;
			rank_q       <= 7'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_LEN: window_len_q <= cfg_data;
				REG_RANK:       rank_q       <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						fill_q <= fill_next;
						if (fill_next >= wl_eff) begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_COUNT;
				end
				ST_COUNT: begin
					if (cnt_q == CW'(MAX_WINDOW - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_COLLECT;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_COLLECT: begin
					if (cnt_q == CW'(MAX_WINDOW)) begin
						if (out_free) begin
							m_tvalid_q <= 1'b1;
							state_q    <= ST_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_COLLECT) && (cnt_q == CW'(MAX_WINDOW)) && out_free) begin
			m_tdata_q <= 16'(res_w[MAX_WINDOW-1]);
		end
	end

endmodule
